// ===== design/les_pkg.sv =====
// les_pkg: shared types, codes and helpers for the light event scheduler
// no dependencies; imported by the cell, the top level and the checker
package les_pkg;

  // request function codes
  typedef enum logic [1:0] {
    FUNC_ON     = 2'd0,
    FUNC_OFF    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ON     = 2'd1,
    KIND_OFF    = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  // schedule status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // day codes beyond the single weekdays
  localparam logic [3:0] DAY_EVERY   = 4'd7;
  localparam logic [3:0] DAY_WEEKDAY = 4'd8;
  localparam logic [3:0] DAY_WEEKEND = 4'd9;
  localparam logic [2:0] WD_SUNDAY   = 3'd0;
  localparam logic [2:0] WD_MONDAY   = 3'd1;
  localparam logic [2:0] WD_FRIDAY   = 3'd5;
  localparam logic [2:0] WD_SATURDAY = 3'd6;

  // stored event of one slot
  typedef struct packed {
    logic [7:0]  light_id;
    logic [3:0]  day;
    logic [10:0] minute;
    logic        turn_on;
  } entry_t;

  // request token walking down the chain, with the held-back tick result
  typedef struct packed {
    logic        valid;
    func_e       func;
    logic        rej;
    logic        placed;
    logic [7:0]  light_id;
    logic [3:0]  day;
    logic [10:0] minute;
    logic [2:0]  now_day;
    logic [10:0] now_minute;
    logic        pend_valid;
    logic        pend_on;
    logic [7:0]  pend_id;
  } token_t;

  // command released by a cell toward the output register
  typedef struct packed {
    logic       valid;
    logic       turn_on;
    logic [7:0] light_id;
  } emit_t;

  // does a day code cover the current weekday
  function automatic logic due_today(logic [3:0] code, logic [2:0] today);
    logic hit;
    hit = (code == DAY_EVERY) || (code == {1'b0, today});
    if (code == DAY_WEEKEND && (today == WD_SUNDAY || today == WD_SATURDAY)) hit = 1'b1;
    if (code == DAY_WEEKDAY && today >= WD_MONDAY && today <= WD_FRIDAY) hit = 1'b1;
    return hit;
  endfunction

endpackage

// ===== design/les_if.sv =====
// les_if: request and result channel interfaces of the light event scheduler
// valid/ready handshake with plain payload vectors; no dependencies
interface les_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  light_id;
  logic [3:0]  day;
  logic [10:0] minute;
  logic [2:0]  now_day;
  logic [10:0] now_minute;

  modport source (output valid, func, light_id, day, minute, now_day, now_minute,
                  input ready);
  modport sink   (input valid, func, light_id, day, minute, now_day, now_minute,
                  output ready);
endinterface

interface les_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] status;
  logic [7:0] light_out;
  logic       last;

  modport source (output valid, kind, status, light_out, last, input ready);
  modport sink   (input valid, kind, status, light_out, last, output ready);
endinterface

// ===== design/light_event_scheduler.sv =====
// light_event_scheduler: table of scheduled light events as a chain of slot cells
// depends on les_pkg, les_req_if / les_rsp_if and les_cell
//
// Usage:
//   req_i carries one request per transfer: schedule on/off, remove, or a
//   minute tick. rsp_o returns the results; last marks the final result of a
//   request. Schedule gives one status result, remove gives none, a tick gives
//   one on/off command per due slot in slot order, or one done marker.
//   The block handles one request at a time. An accepted request walks the
//   chain of EVENTS cells, one cell per cycle while the chain is not stalled,
//   then a tail stage issues its closing result before req_i.ready rises
//   again. The walk over the cells sets the request rate.
//   A tick result is held back one match so that last can be set; a match
//   that releases a held result while rsp_o holds an untaken result stalls
//   the whole chain until the result register frees, so no result is lost.
//   Reset clears every slot valid bit, the chain and the result valid bit;
//   slot contents are not cleared and no clearing pass is needed.
module light_event_scheduler #(
  parameter int EVENTS = 64,
  parameter int LIGHTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  les_req_if.sink     req_i,
  les_rsp_if.source   rsp_o
);
  import les_pkg::*;

  token_t tok_chain [EVENTS+1];
  emit_t  emit      [EVENTS];
  emit_t  emit_any;
  token_t tail_q, tail_d;
  logic   busy_q, busy_d;
  logic   out_free, adv, accept;
  logic   tail_needs_out, tail_fin;

  logic       out_valid_q, out_valid_d;
  kind_e      out_kind_q, out_kind_d;
  status_e    out_status_q, out_status_d;
  logic [7:0] out_light_q, out_light_d;
  logic       out_last_q, out_last_d;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !busy_q;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // build the token for an accepted request
  always_comb begin
    tok_chain[0]            = '0;
    tok_chain[0].valid      = accept;
    tok_chain[0].func       = func_e'(req_i.func);
    tok_chain[0].light_id   = req_i.light_id;
    tok_chain[0].day        = req_i.day;
    tok_chain[0].minute     = req_i.minute;
    tok_chain[0].now_day    = req_i.now_day;
    tok_chain[0].now_minute = req_i.now_minute;
    tok_chain[0].rej        = ({1'b0, req_i.light_id} >= 9'(LIGHTS));
  end

  // chain of slot cells
  for (genvar g = 0; g < EVENTS; g++) begin : g_cell
    les_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok_chain[g]),
      .tok_o  (tok_chain[g+1]),
      .emit_o (emit[g])
    );
  end

  // only the cell holding the token can emit, so an or-merge selects it
  always_comb begin
    emit_any = '0;
    for (int i = 0; i < EVENTS; i++) begin
      emit_any = emit_any | emit[i];
    end
  end

  assign adv = !emit_any.valid || out_free;

  // tail stage: closing result of the request
  assign tail_needs_out = tail_q.valid && (tail_q.func != FUNC_REMOVE);
  assign tail_fin       = tail_q.valid && (!tail_needs_out || out_free);

  always_comb begin
    tail_d = tail_q;
    busy_d = busy_q;
    if (accept) busy_d = 1'b1;
    if (tail_fin) begin
      tail_d = '0;
      busy_d = 1'b0;
    end else if (!tail_q.valid && adv) begin
      tail_d = tok_chain[EVENTS];
    end
  end

  // result register load
  always_comb begin
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_kind_d   = out_kind_q;
    out_status_d = out_status_q;
    out_light_d  = out_light_q;
    out_last_d   = out_last_q;
    if (emit_any.valid && out_free) begin
      out_valid_d  = 1'b1;
      out_kind_d   = emit_any.turn_on ? KIND_ON : KIND_OFF;
      out_status_d = ST_OK;
      out_light_d  = emit_any.light_id;
      out_last_d   = 1'b0;
    end else if (tail_fin && tail_needs_out) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b1;
      if (tail_q.func == FUNC_TICK) begin
        out_status_d = ST_OK;
        if (tail_q.pend_valid) begin
          out_kind_d  = tail_q.pend_on ? KIND_ON : KIND_OFF;
          out_light_d = tail_q.pend_id;
        end else begin
          out_kind_d  = KIND_DONE;
          out_light_d = '0;
        end
      end else begin
        out_kind_d  = KIND_STATUS;
        out_light_d = '0;
        if (tail_q.rej) out_status_d = ST_BAD_ID;
        else if (tail_q.placed) out_status_d = ST_OK;
        else out_status_d = ST_FULL;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q      <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tail_q      <= tail_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_kind_q   <= out_kind_d;
    out_status_q <= out_status_d;
    out_light_q  <= out_light_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.kind      = out_kind_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.light_out = out_light_q;
  assign rsp_o.last      = out_last_q;

endmodule

// ===== design/les_cell.sv =====
// les_cell: one table slot plus the token stage that passes over it
// depends on les_pkg for the token, entry and emit types
module les_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  les_pkg::token_t tok_i,
  output les_pkg::token_t tok_o,
  output les_pkg::emit_t  emit_o
);
  import les_pkg::*;

  token_t tok_q;
  logic   vld_q, vld_d;
  entry_t ent_q;
  logic   wr_en;

  // act on the slot for the token held in this stage
  always_comb begin
    tok_o  = tok_q;
    emit_o = '0;
    vld_d  = vld_q;
    wr_en  = 1'b0;
    if (tok_q.valid) begin
      case (tok_q.func)
        FUNC_ON, FUNC_OFF: begin
          if (!tok_q.rej && !tok_q.placed && !vld_q) begin
            vld_d        = 1'b1;
            wr_en        = 1'b1;
            tok_o.placed = 1'b1;
          end
        end
        FUNC_REMOVE: begin
          if (vld_q && ent_q.light_id == tok_q.light_id && ent_q.day == tok_q.day &&
              ent_q.minute == tok_q.minute) begin
            vld_d = 1'b0;
          end
        end
        FUNC_TICK: begin
          if (vld_q && due_today(ent_q.day, tok_q.now_day) &&
              ent_q.minute == tok_q.now_minute) begin
            // release the held match, hold this one until we know if it is last
            emit_o.valid     = tok_q.pend_valid;
            emit_o.turn_on   = tok_q.pend_on;
            emit_o.light_id  = tok_q.pend_id;
            tok_o.pend_valid = 1'b1;
            tok_o.pend_on    = ent_q.turn_on;
            tok_o.pend_id    = ent_q.light_id;
          end
        end
        default: ;
      endcase
    end
  end

  // token stage and valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      vld_q <= 1'b0;
    end else if (adv_i) begin
      tok_q <= tok_i;
      vld_q <= vld_d;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (adv_i && wr_en) begin
      ent_q <= '{light_id: tok_q.light_id, day: tok_q.day, minute: tok_q.minute,
                 turn_on: (tok_q.func == FUNC_ON)};
    end
  end

endmodule

// ===== design/les_checker.sv =====
// les_checker: port-level checks of the light event scheduler, bound to the top
// depends on les_pkg for the kind and status codes
module les_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [1:0] out_status_i,
  input logic [7:0] out_light_i,
  input logic       out_last_i
);
  import les_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
    $stable(out_light_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // one request at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // only status results carry a status
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_STATUS |-> out_status_i == ST_OK)
    else $error("status set on a command result");

  // status and done results close their request and name no light
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_STATUS || out_kind_i == KIND_DONE)
    |-> out_last_i && out_light_i == 8'd0)
    else $error("single result not marked last");

endmodule

bind light_event_scheduler les_checker u_les_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_kind_i   (rsp_o.kind),
  .out_status_i (rsp_o.status),
  .out_light_i  (rsp_o.light_out),
  .out_last_i   (rsp_o.last)
);
